@@ hw/rtl/addressed_command_line_parser_assert.svh @@
// ----------------------------------------------------------------------------
// addressed command line parser assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ADDRESSED_COMMAND_LINE_PARSER_ASSERT_SVH
`define ADDRESSED_COMMAND_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define ACL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acl assertion failed");

// next-cycle implication
`define ACL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acl assertion failed");

`endif

@@ hw/rtl/acl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_pkg
// shared widths, character codes, register indexes and the result record
// of the addressed command line parser
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam int MAX_CMD_CHARS = 8;
  localparam int VALUE_BITS    = 32;

  localparam int CHAR_W        = 8;
  localparam int CMD_TEXT_W    = 64;
  localparam int CMD_LEN_W     = 4;
  localparam int FIELD_VALUE_W = 32;
  localparam int FIELD_INDEX_W = 8;
  localparam int CFG_DATA_W    = 8;
  localparam int CFG_INDEX_W   = 1;

  localparam int WLEN_W = $clog2(MAX_CMD_CHARS + 1);
  localparam int WIDX_W = (MAX_CMD_CHARS > 1) ? $clog2(MAX_CMD_CHARS) : 1;

  localparam int DECIMAL_BASE = 10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;
  localparam logic [CHAR_W-1:0] UPPER_A         = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z         = 8'h5a;
  localparam logic [CHAR_W-1:0] LOWER_A         = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z         = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DEL        = 8'h7f;
  localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 8'h2c;
  localparam logic [CHAR_W-1:0] UNIT_ID_RESET   = 8'h00;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UNIT_ID   = 1'b0,
    REG_SEPARATOR = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CMD_TEXT_W-1:0]    command_text;
    logic [CMD_LEN_W-1:0]     command_length;
    logic                     command_overflow;
    logic [FIELD_VALUE_W-1:0] field_value;
    logic [FIELD_INDEX_W-1:0] field_index;
  } result_t;

endpackage

@@ hw/rtl/acl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_if
// valid/ready channels of the parser: received characters and commands
// ----------------------------------------------------------------------------
interface acl_char_if import acl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface acl_cmd_if import acl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_TEXT_W-1:0]    command_text;
  logic [CMD_LEN_W-1:0]     command_length;
  logic                     command_overflow;
  logic [FIELD_VALUE_W-1:0] field_value;
  logic [FIELD_INDEX_W-1:0] field_index;

  modport source (output valid, output command_text, output command_length,
                  output command_overflow, output field_value, output field_index,
                  input ready);
  modport sink   (input valid, input command_text, input command_length,
                  input command_overflow, input field_value, input field_index,
                  output ready);
endinterface

@@ hw/rtl/addressed_command_line_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_command_line_parser
// addressed line parser: header number must match unit_id, then letters form
// a command word and digits a field value, closed by separator or control
//
//   channel   dir   payload
//   chars     in    char_code
//   cmds      out   command_text, command_length, command_overflow,
//                   field_value, field_index
//   cfg       in    cfg_write_en, cfg_index, cfg_data (no read-back)
//
// one character per cycle while no closing character waits on the result register;
// a command reaches cmds through the input register, then the result register
// rst is synchronous; it clears the line state and loads unit_id 0, comma
// while a command waits on cmds, characters that close no field still pass;
// a character that closes a field waits in the input register for the result register
// ----------------------------------------------------------------------------
`include "addressed_command_line_parser_assert.svh"

module addressed_command_line_parser import acl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  acl_char_if.sink               chars,
  acl_cmd_if.source              cmds
);

  logic [CHAR_W-1:0] unit_id;
  logic [CHAR_W-1:0] separator_char;

  logic              stage_valid;
  logic [CHAR_W-1:0] stage_char;
  logic              emit;
  logic              can_take;
  logic              advance;
  result_t           result;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id        <= UNIT_ID_RESET;
      separator_char <= SEPARATOR_RESET;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_UNIT_ID:   unit_id        <= cfg_data;
        REG_SEPARATOR: separator_char <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance     = stage_valid && (!emit || can_take);
  assign chars.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      stage_char <= chars.char_code;
    end
  end

  acl_parse_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .char_code      (stage_char),
    .unit_id        (unit_id),
    .separator_char (separator_char),
    .emit           (emit),
    .result         (result)
  );

  acl_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .result   (result),
    .can_take (can_take),
    .cmds     (cmds)
  );

  `ACL_ASSERT_NEXT(a_emit_shows, advance && emit, cmds.valid)
  `ACL_ASSERT_NEXT(a_stage_holds, stage_valid && emit && !can_take,
                   stage_valid && $stable(stage_char))
  `ACL_ASSERT_IMPL(a_no_overrun, stage_valid && emit && cmds.valid && !cmds.ready,
                   !advance)

endmodule

@@ hw/rtl/acl_parse_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_parse_core
// line state and one-character update: header match, digit accumulation,
// command word capture and field close
// ----------------------------------------------------------------------------
`include "addressed_command_line_parser_assert.svh"

module acl_parse_core import acl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [CHAR_W-1:0] unit_id,
  input  logic [CHAR_W-1:0] separator_char,
  output logic              emit,
  output result_t           result
);

  logic                     waiting;
  logic [FIELD_INDEX_W-1:0] dcount;
  logic [VALUE_BITS-1:0]    acc;
  logic [WLEN_W-1:0]        wlen;
  logic                     wovf;
  logic [CHAR_W-1:0]        word [MAX_CMD_CHARS];

  logic                     waiting_next;
  logic [FIELD_INDEX_W-1:0] dcount_next;
  logic [VALUE_BITS-1:0]    acc_next;
  logic [WLEN_W-1:0]        wlen_next;
  logic                     wovf_next;
  logic                     word_we;

  logic                  is_digit;
  logic                  is_letter;
  logic                  is_control;
  logic                  is_sep;
  logic                  head_match;
  logic [VALUE_BITS-1:0] acc_digit;
  logic [CMD_TEXT_W-1:0] text;

  assign is_digit   = char_code inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_letter  = char_code inside {[UPPER_A:UPPER_Z], [LOWER_A:LOWER_Z]};
  assign is_control = (char_code < CHAR_SPACE) || (char_code == CHAR_DEL);
  assign is_sep     = (char_code == separator_char);
  assign head_match = (acc == VALUE_BITS'(unit_id));
  assign acc_digit  = VALUE_BITS'(acc * VALUE_BITS'(DECIMAL_BASE))
                      + VALUE_BITS'(char_code[3:0]);

  always_comb begin
    waiting_next = waiting;
    dcount_next  = dcount;
    acc_next     = acc;
    wlen_next    = wlen;
    wovf_next    = wovf;
    word_we      = 1'b0;
    emit         = 1'b0;
    if (waiting && (dcount == '0)) begin
      if (is_digit) begin
        acc_next = acc_digit;
      end else if (is_sep && head_match) begin
        waiting_next = 1'b0;
        acc_next     = '0;
        wlen_next    = '0;
        wovf_next    = 1'b0;
      end
    end else if (!waiting) begin
      if (is_digit) begin
        acc_next = acc_digit;
      end else if (is_letter) begin
        if (wlen < WLEN_W'(MAX_CMD_CHARS)) begin
          word_we   = 1'b1;
          wlen_next = wlen + WLEN_W'(1);
        end else begin
          wovf_next = 1'b1;
        end
      end else if (is_sep || is_control) begin
        emit     = (wlen != '0);
        acc_next = '0;
      end
    end
    if (is_sep) begin
      dcount_next = dcount + FIELD_INDEX_W'(1);
    end
    if (is_control) begin
      acc_next     = '0;
      wlen_next    = '0;
      wovf_next    = 1'b0;
      waiting_next = 1'b1;
      dcount_next  = '0;
    end
  end

  // bytes past the word length read as zero
  always_comb begin
    text = '0;
    for (int i = 0; i < MAX_CMD_CHARS; i++) begin
      if (WLEN_W'(i) < wlen) begin
        text[8*i +: 8] = word[i];
      end
    end
  end

  assign result.command_text     = text;
  assign result.command_length   = CMD_LEN_W'(wlen);
  assign result.command_overflow = wovf;
  assign result.field_value      = FIELD_VALUE_W'(acc);
  assign result.field_index      = dcount - FIELD_INDEX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting <= 1'b1;
      dcount  <= '0;
      acc     <= '0;
      wlen    <= '0;
      wovf    <= 1'b0;
    end else if (fire) begin
      waiting <= waiting_next;
      dcount  <= dcount_next;
      acc     <= acc_next;
      wlen    <= wlen_next;
      wovf    <= wovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && word_we) begin
      word[wlen[WIDX_W-1:0]] <= char_code;
    end
  end

  `ACL_ASSERT_IMPL(a_word_cap, 1'b1, wlen <= WLEN_W'(MAX_CMD_CHARS))
  `ACL_ASSERT_NEXT(a_ctrl_clears, fire && is_control, waiting && dcount == '0 && wlen == '0)
  `ACL_ASSERT_NEXT(a_ovf_full, fire && !is_control && wovf_next && !wovf,
                   wlen == WLEN_W'(MAX_CMD_CHARS))

endmodule

@@ hw/rtl/acl_result_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_result_reg
// result register driving the command channel
// ----------------------------------------------------------------------------
module acl_result_reg import acl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  result_t  result,
  output logic     can_take,
  acl_cmd_if.source cmds
);

  logic    valid;
  result_t data;

  assign can_take = !valid || cmds.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (cmds.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign cmds.valid            = valid;
  assign cmds.command_text     = data.command_text;
  assign cmds.command_length   = data.command_length;
  assign cmds.command_overflow = data.command_overflow;
  assign cmds.field_value      = data.field_value;
  assign cmds.field_index      = data.field_index;

endmodule
